### rtl/core/eatrm_pkg.sv
`timescale 1ns / 1ps
package eatrm_pkg;
  localparam int unsigned CordicSteps = 20;
  localparam int unsigned VecW = 34;
  localparam int unsigned ZW = 33;

  typedef logic signed [VecW-1:0] vec_t;
  typedef logic signed [ZW-1:0] zang_t;

  localparam logic signed [VecW-1:0] CordicX0 = 34'sd652032874;
  localparam logic signed [VecW-1:0] Q30One = 34'sd1073741824;

  function automatic zang_t atan_q32(input int unsigned i);
    zang_t r;
    r = '0;
    case (i)
      0: r = 33'sd536870912;
      1: r = 33'sd316933406;
      2: r = 33'sd167458907;
      3: r = 33'sd85004756;
      4: r = 33'sd42667331;
      5: r = 33'sd21354465;
      6: r = 33'sd10679838;
      7: r = 33'sd5340245;
      8: r = 33'sd2670163;
      9: r = 33'sd1335087;
      10: r = 33'sd667544;
      11: r = 33'sd333772;
      12: r = 33'sd166886;
      13: r = 33'sd83443;
      14: r = 33'sd41722;
      15: r = 33'sd20861;
      16: r = 33'sd10430;
      17: r = 33'sd5215;
      18: r = 33'sd2608;
      19: r = 33'sd1304;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage

### rtl/core/euler_angles_to_rotation_matrix_core.sv
`timescale 1ns / 1ps
// zyx euler angles to rotation matrix, fully pipelined: one angle triple per
// cycle, one word out per cycle while the master side does not stall. there
// are 27 register stages: 1 reduction stage, 20 cordic stages (one
// micro-rotation each, three angles in parallel), clamp, first products,
// rounding to q30, second products, summing, and output rounding into the
// output register. a stall on the master side freezes the whole pipe;
// s_axis_tready drops only when the last stage holds a word that is not
// taken. writing 1 to the order bit via cfg_we_i gives the transpose.
module euler_angles_to_rotation_matrix_core #(
  parameter int unsigned ANGLE_BITS = 16,
  parameter int unsigned OUT_FRAC_BITS = 14
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // roll, pitch, yaw, each ANGLE_BITS, lowest first
  input  logic [((3*ANGLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // r11 r12 r13 r21 r22 r23 r31 r32 r33, each OUT_FRAC_BITS+2, lowest first
  output logic [((9*(OUT_FRAC_BITS+2)+7)/8)*8-1:0] m_axis_tdata
);
  localparam int unsigned N = eatrm_pkg::CordicSteps;
  localparam int unsigned OW = OUT_FRAC_BITS + 2;
  localparam int unsigned ST = N + 7;
  localparam int unsigned ZWM = eatrm_pkg::ZW - 1;

  logic adv;
  logic [ST-1:0] vld_q;
  logic seq_q;

  assign adv = !vld_q[ST-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[ST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= 1'b0;
      vld_q <= '0;
    end else begin
      if (cfg_we_i) seq_q <= cfg_wdata_i;
      if (adv) vld_q <= {vld_q[ST-2:0], s_axis_tvalid};
    end
  end

  // angle reduction, three angles
  eatrm_pkg::vec_t x_q [N+1][3];
  eatrm_pkg::vec_t y_q [N+1][3];
  eatrm_pkg::zang_t z_q [N+1][3];
  logic flip_q [N+1][3];

  for (genvar a = 0; a < 3; a++) begin : g_ang
    logic [31:0] aw;
    logic fl;
    assign aw = {s_axis_tdata[a*ANGLE_BITS +: ANGLE_BITS], {(32-ANGLE_BITS){1'b0}}};
    assign fl = aw[31] ^ aw[30];
    always_ff @(posedge clk_i) begin
      if (adv) begin
        x_q[0][a] <= eatrm_pkg::CordicX0;
        y_q[0][a] <= '0;
        z_q[0][a] <= eatrm_pkg::zang_t'($signed({aw[31] ^ fl, aw[30:0]}));
        flip_q[0][a] <= fl;
      end
    end
    for (genvar i = 0; i < N; i++) begin : g_step
      eatrm_pkg::vec_t dx, dy;
      assign dx = x_q[i][a] >>> i;
      assign dy = y_q[i][a] >>> i;
      always_ff @(posedge clk_i) begin
        if (adv) begin
          flip_q[i+1][a] <= flip_q[i][a];
          if (!z_q[i][a][ZWM]) begin
            x_q[i+1][a] <= x_q[i][a] - dy;
            y_q[i+1][a] <= y_q[i][a] + dx;
            z_q[i+1][a] <= z_q[i][a] - eatrm_pkg::atan_q32(i);
          end else begin
            x_q[i+1][a] <= x_q[i][a] + dy;
            y_q[i+1][a] <= y_q[i][a] - dx;
            z_q[i+1][a] <= z_q[i][a] + eatrm_pkg::atan_q32(i);
          end
        end
      end
    end
  end

  function automatic logic signed [31:0] fix(input eatrm_pkg::vec_t v, input logic f);
    eatrm_pkg::vec_t t;
    t = f ? -v : v;
    if (t > eatrm_pkg::Q30One) t = eatrm_pkg::Q30One;
    else if (t < -eatrm_pkg::Q30One) t = -eatrm_pkg::Q30One;
    return t[31:0];
  endfunction

  // sin/cos clamp: index 0 roll, 1 pitch, 2 yaw
  logic signed [31:0] s_q [3];
  logic signed [31:0] c_q [3];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        s_q[a] <= fix(y_q[N][a], flip_q[N][a]);
        c_q[a] <= fix(x_q[N][a], flip_q[N][a]);
      end
    end
  end

  // first products: two-factor terms in q60, pair products for three-factor terms
  logic signed [63:0] p_q [9];
  logic signed [31:0] sph1_q, cph1_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_q[0] <= c_q[2] * c_q[1];
      p_q[1] <= s_q[2] * c_q[0];
      p_q[2] <= s_q[2] * s_q[0];
      p_q[3] <= s_q[2] * c_q[1];
      p_q[4] <= c_q[2] * c_q[0];
      p_q[5] <= c_q[2] * s_q[0];
      p_q[6] <= c_q[1] * s_q[0];
      p_q[7] <= c_q[1] * c_q[0];
      p_q[8] <= c_q[2] * s_q[1];
      sph1_q <= s_q[0];
      cph1_q <= c_q[0];
    end
  end
  logic signed [63:0] ps_q;
  logic signed [31:0] sth1_q;
  always_ff @(posedge clk_i) begin
    if (adv) sth1_q <= s_q[1];
  end
  always_ff @(posedge clk_i) begin
    if (adv) ps_q <= s_q[2] * s_q[1];
  end

  // round pair products to q30
  logic signed [63:0] two_q [8];
  logic signed [31:0] tc_q, ts_q, sph2_q, cph2_q, sth2_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 8; k++) two_q[k] <= p_q[k];
      tc_q <= 32'((p_q[8] + 64'sd536870912) >>> 30);
      ts_q <= 32'((ps_q + 64'sd536870912) >>> 30);
      sph2_q <= sph1_q;
      cph2_q <= cph1_q;
      sth2_q <= sth1_q;
    end
  end

  // second products and sums, q60
  logic signed [63:0] m_q [9];
  logic signed [63:0] two3_q [8];
  logic signed [63:0] t3_q [4];
  logic signed [31:0] sth3_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 8; k++) two3_q[k] <= two_q[k];
      t3_q[0] <= tc_q * sph2_q;
      t3_q[1] <= tc_q * cph2_q;
      t3_q[2] <= ts_q * sph2_q;
      t3_q[3] <= ts_q * cph2_q;
      sth3_q <= sth2_q;
    end
  end
  // two3: 0 cps*cth, 1 sps*cph, 2 sps*sph, 3 sps*cth, 4 cps*cph, 5 cps*sph,
  // 6 cth*sph, 7 cth*cph
  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_q[0] <= two3_q[0];
      m_q[1] <= t3_q[0] - two3_q[1];
      m_q[2] <= t3_q[1] + two3_q[2];
      m_q[3] <= two3_q[3];
      m_q[4] <= t3_q[2] + two3_q[4];
      m_q[5] <= t3_q[3] - two3_q[5];
      m_q[6] <= -(64'(sth3_q) <<< 30);
      m_q[7] <= two3_q[6];
      m_q[8] <= two3_q[7];
    end
  end

  function automatic logic [OW-1:0] rnd(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = (v + (64'sd1 <<< (59-OUT_FRAC_BITS))) >>> (60-OUT_FRAC_BITS);
    if (t > (64'sd1 <<< OUT_FRAC_BITS)) t = 64'sd1 <<< OUT_FRAC_BITS;
    else if (t < -(64'sd1 <<< OUT_FRAC_BITS)) t = -(64'sd1 <<< OUT_FRAC_BITS);
    return t[OW-1:0];
  endfunction

  // output rounding and transpose select
  logic [OW-1:0] r_q [9];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < 3; r++)
        for (int k = 0; k < 3; k++)
          r_q[r*3+k] <= rnd(seq_q ? m_q[k*3+r] : m_q[r*3+k]);
    end
  end

  always_comb begin
    m_axis_tdata = '0;
    for (int k = 0; k < 9; k++) m_axis_tdata[k*OW +: OW] = r_q[k];
  end

`ifndef ASSERT_OFF
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed under stall");
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("ready does not follow output stall");
  a_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !vld_q[ST-1] == 1'b0)
    else $error("valid without pipe word");
`endif
endmodule

### bench/tb.sv
`timescale 1ns / 1ps
module tb;
  localparam int AngW = 16;
  localparam int OutW = 16;
  localparam int InBits = 48;
  localparam int OutBits = 144;
  localparam int MaxCycles = 400000;

  // register value that selects the transposed (xyz) matrix
  localparam bit SeqZyx = 1'b0;
  localparam bit SeqXyz = 1'b1;

  typedef logic signed [OutW-1:0] entry_t;
  typedef struct packed {
    entry_t r33, r32, r31, r23, r22, r21, r13, r12, r11;
  } matrix_t;

  // scoreboard: predicts the rotation matrix for every accepted angle triple
  class matrix_scoreboard;
    matrix_t pending_mats[$];
    bit seq_xyz;
    int mismatches;
    int checked;

    function new();
      seq_xyz = SeqZyx;
      mismatches = 0;
      checked = 0;
    endfunction

    static function longint fshift(longint v, int s);
      return v >>> s;
    endfunction

    static function longint clampv(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    static function void sin_cos(logic [AngW-1:0] ang, output longint s, output longint c);
      logic [31:0] a;
      bit flip;
      longint x, y, z, dx, dy;
      longint atans[20];
      atans = '{536870912, 316933406, 167458907, 85004756, 42667331,
                21354465, 10679838, 5340245, 2670163, 1335087,
                667544, 333772, 166886, 83443, 41722,
                20861, 10430, 5215, 2608, 1304};
      a = {ang, 16'h0};
      flip = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
      if (flip) a = a + 32'h8000_0000;
      z = longint'($signed(a));
      x = 652032874;
      y = 0;
      for (int i = 0; i < 20; i++) begin
        dx = fshift(y, i);
        dy = fshift(x, i);
        if (z >= 0) begin
          x -= dx; y += dy; z -= atans[i];
        end else begin
          x += dx; y -= dy; z += atans[i];
        end
      end
      if (flip) begin
        x = -x; y = -y;
      end
      c = clampv(x, 64'sd1 << 30);
      s = clampv(y, 64'sd1 << 30);
    endfunction

    static function longint triple(longint a, longint b, longint c);
      return fshift(a * b + (64'sd1 << 29), 30) * c;
    endfunction

    static function entry_t round_q14(longint q60);
      return entry_t'(clampv(fshift(q60 + (64'sd1 << 45), 46), 64'sd1 << 14));
    endfunction

    function void note_angles(logic [InBits-1:0] word);
      longint sph, cph, sth, cth, sps, cps;
      longint m[9];
      entry_t e[9];
      matrix_t mat;
      sin_cos(word[15:0], sph, cph);
      sin_cos(word[31:16], sth, cth);
      sin_cos(word[47:32], sps, cps);
      m[0] = cps * cth;
      m[1] = triple(cps, sth, sph) - sps * cph;
      m[2] = triple(cps, sth, cph) + sps * sph;
      m[3] = sps * cth;
      m[4] = triple(sps, sth, sph) + cps * cph;
      m[5] = triple(sps, sth, cph) - cps * sph;
      m[6] = -sth * (64'sd1 << 30);
      m[7] = cth * sph;
      m[8] = cth * cph;
      for (int r = 0; r < 3; r++)
        for (int k = 0; k < 3; k++)
          e[r*3+k] = round_q14(m[seq_xyz ? k*3+r : r*3+k]);
      mat = {e[8], e[7], e[6], e[5], e[4], e[3], e[2], e[1], e[0]};
      pending_mats.insert(pending_mats.size(), mat);
    endfunction

    function void check_matrix(logic [OutBits-1:0] word);
      matrix_t want, got;
      got = word;
      if (pending_mats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("error: unexpected matrix %h", word);
        return;
      end
      want = pending_mats.pop_front();
      checked++;
      for (int f = 0; f < 9; f++)
        if (got[f*OutW +: OutW] !== want[f*OutW +: OutW]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("error: matrix %0d entry %0d expected %0d got %0d", checked, f,
                     $signed(want[f*OutW +: OutW]), $signed(got[f*OutW +: OutW]));
        end
    endfunction
  endclass

  logic clk_i, rst_ni, cfg_we_i, cfg_wdata_i;
  logic s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready;
  logic [InBits-1:0] s_axis_tdata;
  logic [OutBits-1:0] m_axis_tdata;

  matrix_scoreboard sb;
  int cycles;
  bit hold_off;
  int sent;

  euler_angles_to_rotation_matrix_core u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // monitor and timeout
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_matrix(m_axis_tdata);
    if (rst_ni && s_axis_tvalid && s_axis_tready) sb.note_angles(s_axis_tdata);
    if (cycles > MaxCycles) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL euler_angles_to_rotation_matrix_core");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off when asked
  initial begin
    int w;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (150) @(negedge clk_i);
        hold_off = 1'b0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (sent > 300 && sent < 380) w = 0;
      if (w == 0) m_axis_tready <= 1'b1;
      else begin
        m_axis_tready <= 1'b0;
        repeat (w - 1) @(negedge clk_i);
        @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_angles(logic [15:0] roll, logic [15:0] pitch, logic [15:0] yaw,
                             bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {yaw, pitch, roll};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_mats.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_order(bit v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.seq_xyz = v;
  endtask

  logic [15:0] corner[12] = '{16'h0000, 16'h7fff, 16'h8000, 16'h4000, 16'hc000, 16'h2000,
                              16'h3fff, 16'h4001, 16'hbfff, 16'hc001, 16'h0001, 16'hffff};

  initial begin
    sb = new();
    cycles = 0;
    sent = 0;
    hold_off = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: quadrant edges and full-scale angles on each axis
    for (int i = 0; i < 12; i++)
      send_angles(corner[i], corner[(i + 3) % 12], corner[(i + 7) % 12], 1'b0);
    send_angles(16'h7fff, 16'h8000, 16'h7fff, 1'b0);
    send_angles(16'h8000, 16'h7fff, 16'h8000, 1'b0);
    send_angles(16'h1234, 16'h4000, 16'hedcb, 1'b0);
    send_angles(16'h5555, 16'hc000, 16'haaaa, 1'b0);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_order(ph[0] ? SeqXyz : SeqZyx);
      if (ph == 1) begin
        // same corners on the transposed order
        for (int i = 0; i < 12; i++)
          send_angles(corner[i], corner[(i + 5) % 12], corner[(i + 2) % 12], 1'b0);
      end
      if (ph == 2) hold_off = 1'b1;
      for (int n = 0; n < 120; n++) begin
        logic [15:0] a, b, c;
        a = $urandom; b = $urandom; c = $urandom;
        if ($urandom_range(0, 9) == 0) b = corner[$urandom_range(0, 11)];
        send_angles(a, b, c, ph == 2 || (n % 40) < 10);
      end
      // pause until every matrix is back
      drain();
    end

    $display("sent %0d angle triples, checked %0d matrices in zyx and xyz order",
             sent, sb.checked);
    if (sb.mismatches == 0 && sb.pending_mats.size() == 0)
      $display("PASS euler_angles_to_rotation_matrix_core");
    else begin
      $display("%0d mismatches", sb.mismatches);
      $display("FAIL euler_angles_to_rotation_matrix_core");
    end
    $finish;
  end
endmodule
